// ===== rtl/lccc_pkg.sv =====
// Package for the LRU cache shard: sizes, command and status codes, types.
// No dependencies.
package lccc_pkg;
   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int KEY_BITS   = 32;
   localparam int VAL_BITS   = 32;
   localparam int CHG_BITS   = 16;
   localparam int USE_BITS   = 20;
   localparam int REF_BITS   = 8;
   localparam int CMD_BITS   = 2;
   localparam int STAT_BITS  = 3;
   // key, value, charge packed in one RAM word
   localparam int ENT_BITS   = KEY_BITS + VAL_BITS + CHG_BITS;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ERASE   = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd3;

   localparam logic [STAT_BITS-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_MISS    = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_NOSLOT  = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_FREEREL = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_REFFULL = 3'd4;

   localparam logic [REF_BITS-1:0] REFS_MAX = 8'd255;
   localparam logic [USE_BITS-1:0] USE_MAX  = 20'hFFFFF;

   typedef struct packed {
      logic [REF_BITS-1:0]  refs;
      logic                 listed;
      logic [SLOT_BITS-1:0] age;
   } meta_type;
endpackage

// ===== rtl/lccc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lccc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/lru_cache_charge_capacity.sv =====
// Top level of the LRU cache shard: sequencer, entry RAM and per-slot metadata.
// Depends on lccc_pkg and lccc_ram.
//
// Channel  | Direction | Handshake                 | Word
// req_     | in        | start high, busy low      | cmd, key, value, charge, slot
// rsp_     | out       | rsp_strobe for one cycle  | status, handle, found_value, usage
// csr_     | in        | csr_wr_en                 | capacity
//
// Accepted word to result word: release passes S_DECIDE and S_DONE; lookup and erase
// first search, reading one entry RAM word per cycle; insert adds S_REPL and S_EVSCAN,
// evicting at most SLOTS entries. A new word can be taken while rsp_strobe is high.
// Reset clears all metadata and usage at once; entry RAM contents are unknown until
// written. The receiver cannot stall: rsp_strobe is one cycle wide.
module lru_cache_charge_capacity
   import lccc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_BITS-1:0]  req_cmd,
   input  logic [KEY_BITS-1:0]  req_key,
   input  logic [VAL_BITS-1:0]  req_value,
   input  logic [CHG_BITS-1:0]  req_charge,
   input  logic [SLOT_BITS-1:0] req_slot,
   input  logic                 csr_wr_en,
   input  logic [USE_BITS-1:0]  csr_wr_data,
   output logic                 rsp_strobe,
   output logic [STAT_BITS-1:0] rsp_status,
   output logic [SLOT_BITS-1:0] rsp_handle,
   output logic [VAL_BITS-1:0]  rsp_found_value,
   output logic [USE_BITS-1:0]  rsp_usage
);
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_DECIDE = 6'b000100,
      S_REPL   = 6'b001000,
      S_EVSCAN = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [USE_BITS-1:0]      cap_ff;
   logic [USE_BITS-1:0]      usage_ff, usage_in;
   meta_type                 meta_ff [SLOTS];
   meta_type                 meta_in [SLOTS];
   logic [CMD_BITS-1:0]      cmd_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [VAL_BITS-1:0]      val_ff;
   logic [CHG_BITS-1:0]      chg_ff;
   logic [SLOT_BITS-1:0]     slot_ff;
   // search address counter, one beyond to flush the last read
   logic [SLOT_BITS:0]       addr_ff, addr_in;
   logic [SLOT_BITS-1:0]     rdidx_ff;
   logic                     rdv_ff;
   logic                     hit_ff, hit_in;
   logic [SLOT_BITS-1:0]     hidx_ff, hidx_in;
   logic [VAL_BITS-1:0]      hval_ff, hval_in;
   logic [SLOT_BITS:0]       guard_ff, guard_in;
   logic [SLOT_BITS-1:0]     fslot_ff, fslot_in;
   logic [STAT_BITS-1:0]     st_ff, st_in;
   logic [SLOT_BITS-1:0]     hd_ff, hd_in;
   logic [VAL_BITS-1:0]      fv_ff, fv_in;
   logic                     strobe_in;

   logic                     ram_we;
   logic [SLOT_BITS-1:0]     ram_wa;
   logic [ENT_BITS-1:0]      ram_wd, ram_rd;
   logic [SLOT_BITS-1:0]     ram_ra;
   logic [CHG_BITS-1:0]      chg_q [SLOTS];

   // charges kept beside metadata so a drop can subtract without a RAM read
   logic [CHG_BITS-1:0]      chgr_ff [SLOTS];

   lccc_ram #(.WIDTH(ENT_BITS), .DEPTH(SLOTS)) u_ent (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // new entry is written once its free slot is registered
   assign ram_ra = addr_ff[SLOT_BITS-1:0];
   assign ram_we = (state_ff == S_REPL);
   assign ram_wa = fslot_ff;
   assign ram_wd = {key_ff, val_ff, chg_ff};
   assign busy   = (state_ff != S_IDLE);

   // helper: unlist slot i in a metadata array
   function automatic void do_unlist(inout meta_type m [SLOTS], input logic [SLOT_BITS-1:0] i);
      logic [SLOT_BITS-1:0] a;
      a = m[i].age;
      for (int j = 0; j < SLOTS; j++)
         if (m[j].listed && (j != int'(i)) && m[j].age > a)
            m[j].age = m[j].age - 1'b1;
      m[i].listed = 1'b0;
      m[i].age    = '0;
   endfunction

   function automatic void do_append(inout meta_type m [SLOTS], input logic [SLOT_BITS-1:0] i);
      logic [SLOT_BITS:0] n;
      n = '0;
      for (int j = 0; j < SLOTS; j++)
         if (m[j].listed && (j != int'(i))) n = n + 1'b1;
      m[i].age    = n[SLOT_BITS-1:0];
      m[i].listed = 1'b1;
   endfunction

   function automatic void do_drop(inout meta_type m [SLOTS], inout logic [USE_BITS-1:0] u,
                                   input logic [SLOT_BITS-1:0] i,
                                   input logic [CHG_BITS-1:0] c);
      if (m[i].refs != '0) begin
         m[i].refs = m[i].refs - 1'b1;
         if (m[i].refs == '0) begin
            u = (u >= USE_BITS'(c)) ? u - USE_BITS'(c) : '0;
            if (m[i].listed) do_unlist(m, i);
         end
      end
   endfunction

   always_comb begin
      for (int j = 0; j < SLOTS; j++) chg_q[j] = chgr_ff[j];
   end

   // sequencer
   always_comb begin
      logic                 free;
      logic [SLOT_BITS-1:0] fs;
      logic                 old;
      logic [USE_BITS:0]    sum;
      state_in  = state_ff;
      meta_in   = meta_ff;
      usage_in  = usage_ff;
      addr_in   = addr_ff;
      hit_in    = hit_ff;
      hidx_in   = hidx_ff;
      hval_in   = hval_ff;
      guard_in  = guard_ff;
      fslot_in  = fslot_ff;
      st_in     = st_ff;
      hd_in     = hd_ff;
      fv_in     = fv_ff;
      strobe_in = 1'b0;
      free      = 1'b0;
      fs        = '0;
      old       = 1'b0;
      sum       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in  = '0;
               hit_in   = 1'b0;
               hidx_in  = '0;
               hval_in  = '0;
               guard_in = '0;
               state_in = (req_cmd == CMD_RELEASE) ? S_DECIDE : S_SEARCH;
            end
         end
         S_SEARCH: begin
            // read data of the previous address arrives now
            if (rdv_ff && !hit_ff && meta_ff[rdidx_ff].listed &&
                ram_rd[ENT_BITS-1 -: KEY_BITS] == key_ff) begin
               hit_in  = 1'b1;
               hidx_in = rdidx_ff;
               hval_in = ram_rd[CHG_BITS +: VAL_BITS];
            end
            if (addr_ff == (SLOT_BITS+1)'(SLOTS)) state_in = S_DECIDE;
            else addr_in = addr_ff + 1'b1;
         end
         S_DECIDE: begin
            st_in = ST_OK; hd_in = '0; fv_in = '0;
            state_in = S_DONE;
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (!hit_ff) st_in = ST_MISS;
                  else begin
                     hd_in = hidx_ff; fv_in = hval_ff;
                     if (meta_ff[hidx_ff].refs >= REFS_MAX) st_in = ST_REFFULL;
                     else begin
                        do_unlist(meta_in, hidx_ff);
                        do_append(meta_in, hidx_ff);
                        meta_in[hidx_ff].refs = meta_ff[hidx_ff].refs + 1'b1;
                     end
                  end
               end
               CMD_ERASE: begin
                  if (!hit_ff) st_in = ST_MISS;
                  else begin
                     hd_in = hidx_ff;
                     do_unlist(meta_in, hidx_ff);
                     do_drop(meta_in, usage_in, hidx_ff, chg_q[hidx_ff]);
                  end
               end
               CMD_RELEASE: begin
                  hd_in = slot_ff;
                  if (meta_ff[slot_ff].refs == '0) st_in = ST_FREEREL;
                  else do_drop(meta_in, usage_in, slot_ff, chg_q[slot_ff]);
               end
               default: begin
                  for (int j = SLOTS-1; j >= 0; j--)
                     if (meta_ff[j].refs == '0) begin
                        free = 1'b1; fs = SLOT_BITS'(j);
                     end
                  if (!free) st_in = ST_NOSLOT;
                  else begin
                     fslot_in = fs;
                     hd_in = fs; fv_in = val_ff;
                     meta_in[fs].refs = 8'd2;
                     do_append(meta_in, fs);
                     sum = {1'b0, usage_ff} + (USE_BITS+1)'(chg_ff);
                     usage_in = sum[USE_BITS] ? USE_MAX : sum[USE_BITS-1:0];
                     state_in = S_REPL;
                  end
               end
            endcase
         end
         S_REPL: begin
            old = hit_ff;
            if (old) begin
               do_unlist(meta_in, hidx_ff);
               do_drop(meta_in, usage_in, hidx_ff, chg_q[hidx_ff]);
            end
            state_in = S_EVSCAN;
         end
         S_EVSCAN: begin
            // one eviction per cycle, bounded by SLOTS passes
            if (guard_ff == (SLOT_BITS+1)'(SLOTS) || usage_ff <= cap_ff) state_in = S_DONE;
            else begin
               free = 1'b0;
               for (int j = SLOTS-1; j >= 0; j--)
                  if (meta_ff[j].listed && meta_ff[j].age == '0) begin
                     free = 1'b1; fs = SLOT_BITS'(j);
                  end
               if (!free) state_in = S_DONE;
               else begin
                  do_unlist(meta_in, fs);
                  do_drop(meta_in, usage_in, fs, chg_q[fs]);
                  guard_in = guard_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cap_ff     <= '0;
         usage_ff   <= '0;
         rdv_ff     <= 1'b0;
         rsp_strobe <= 1'b0;
         for (int j = 0; j < SLOTS; j++) meta_ff[j] <= '0;
      end else begin
         state_ff   <= state_in;
         usage_ff   <= usage_in;
         meta_ff    <= meta_in;
         rdv_ff     <= (state_ff == S_SEARCH) && (addr_ff < (SLOT_BITS+1)'(SLOTS));
         rsp_strobe <= strobe_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff  <= req_cmd;
         key_ff  <= req_key;
         val_ff  <= req_value;
         chg_ff  <= req_charge;
         slot_ff <= req_slot;
      end
      if (ram_we) chgr_ff[ram_wa] <= chg_ff;
      addr_ff  <= addr_in;
      rdidx_ff <= addr_ff[SLOT_BITS-1:0];
      hit_ff   <= hit_in;
      hidx_ff  <= hidx_in;
      hval_ff  <= hval_in;
      guard_ff <= guard_in;
      fslot_ff <= fslot_in;
      st_ff    <= st_in;
      hd_ff    <= hd_in;
      fv_ff    <= fv_in;
      if (strobe_in) begin
         rsp_status      <= st_ff;
         rsp_handle      <= hd_ff;
         rsp_found_value <= fv_ff;
         rsp_usage       <= usage_ff;
      end
   end

   // assertions
   a_usage_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |=> usage_ff == $past(usage_ff)) else $error("usage moved when idle");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted word did not raise busy");
endmodule

// ===== sim/lru_cache_charge_capacity_tb.sv =====
// Testbench for the LRU cache shard: directed and random command words checked against
// an in-bench model of the slots, their reference counts, LRU order and charge usage.
// Depends on lccc_pkg and lru_cache_charge_capacity.
`timescale 1ns / 100ps

module lru_cache_charge_capacity_tb;
   import lccc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 80;

   typedef struct {
      logic [STAT_BITS-1:0] status;
      logic [SLOT_BITS-1:0] handle;
      logic [VAL_BITS-1:0]  found_value;
      logic [USE_BITS-1:0]  usage;
   } answer_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [CMD_BITS-1:0]  req_cmd;
   logic [KEY_BITS-1:0]  req_key;
   logic [VAL_BITS-1:0]  req_value;
   logic [CHG_BITS-1:0]  req_charge;
   logic [SLOT_BITS-1:0] req_slot;
   logic                 csr_wr_en;
   logic [USE_BITS-1:0]  csr_wr_data;
   logic                 rsp_strobe;
   logic [STAT_BITS-1:0] rsp_status;
   logic [SLOT_BITS-1:0] rsp_handle;
   logic [VAL_BITS-1:0]  rsp_found_value;
   logic [USE_BITS-1:0]  rsp_usage;

   // shard model
   logic [KEY_BITS-1:0]  slot_key    [SLOTS];
   logic [VAL_BITS-1:0]  slot_value  [SLOTS];
   logic [CHG_BITS-1:0]  slot_charge [SLOTS];
   int                   slot_refs   [SLOTS];
   bit                   slot_listed [SLOTS];
   int                   slot_age    [SLOTS];
   logic [USE_BITS-1:0]  model_usage;
   logic [USE_BITS-1:0]  model_capacity;

   answer_type           pending_answers[$];
   int                   held_handles[$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   bit                   no_gaps;
   answer_type           last_answer;

   lru_cache_charge_capacity u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_value       (req_value),
      .req_charge      (req_charge),
      .req_slot        (req_slot),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_handle      (rsp_handle),
      .rsp_found_value (rsp_found_value),
      .rsp_usage       (rsp_usage)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      error_count++;
   endtask

   // ---------------- model of LRU order and pinning ----------------
   function automatic void order_unlink(input int i);
      slot_listed[i] = 1'b0;
      for (int j = 0; j < SLOTS; j++)
         if (slot_listed[j] && slot_age[j] > slot_age[i]) slot_age[j]--;
      slot_age[i] = 0;
   endfunction

   function automatic void lru_push_newest(input int i);
      int n;
      n = 0;
      for (int j = 0; j < SLOTS; j++)
         if (slot_listed[j] && j != i) n++;
      slot_age[i]    = n;
      slot_listed[i] = 1'b1;
   endfunction

   function automatic void unpin(input int i);
      if (slot_refs[i] == 0) return;
      slot_refs[i]--;
      if (slot_refs[i] == 0) begin
         model_usage = (model_usage >= slot_charge[i]) ? model_usage - slot_charge[i] : '0;
         if (slot_listed[i]) order_unlink(i);
      end
   endfunction

   function automatic int find_key(input logic [KEY_BITS-1:0] k);
      for (int j = 0; j < SLOTS; j++)
         if (slot_listed[j] && slot_key[j] == k) return j;
      return -1;
   endfunction

   // works out the answer to one word and updates the model
   function automatic answer_type predict_answer(input logic [CMD_BITS-1:0] cmd,
                                                 input logic [KEY_BITS-1:0] k,
                                                 input logic [VAL_BITS-1:0] v,
                                                 input logic [CHG_BITS-1:0] c,
                                                 input logic [SLOT_BITS-1:0] s);
      answer_type a;
      int      i;
      int      free_slot;
      int      oldest;
      int      sum;
      a = '{ST_OK, '0, '0, '0};
      case (cmd)
         CMD_LOOKUP: begin
            i = find_key(k);
            if (i < 0) a.status = ST_MISS;
            else begin
               a.handle      = SLOT_BITS'(i);
               a.found_value = slot_value[i];
               if (slot_refs[i] >= REFS_MAX) a.status = ST_REFFULL;
               else begin
                  order_unlink(i);
                  lru_push_newest(i);
                  slot_refs[i]++;
               end
            end
         end
         CMD_INSERT: begin
            free_slot = -1;
            for (int j = 0; j < SLOTS; j++)
               if (free_slot < 0 && slot_refs[j] == 0) free_slot = j;
            if (free_slot < 0) a.status = ST_NOSLOT;
            else begin
               i = find_key(k);
               slot_key[free_slot]    = k;
               slot_value[free_slot]  = v;
               slot_charge[free_slot] = c;
               slot_refs[free_slot]   = 2;
               lru_push_newest(free_slot);
               sum = model_usage + c;
               model_usage = (sum > USE_MAX) ? USE_MAX : USE_BITS'(sum);
               if (i >= 0) begin
                  order_unlink(i);
                  unpin(i);
               end
               // evict oldest listed entries while over capacity
               for (int g = 0; g < SLOTS && model_usage > model_capacity; g++) begin
                  oldest = -1;
                  for (int j = 0; j < SLOTS; j++)
                     if (oldest < 0 && slot_listed[j] && slot_age[j] == 0) oldest = j;
                  if (oldest < 0) break;
                  order_unlink(oldest);
                  unpin(oldest);
               end
               a.handle      = SLOT_BITS'(free_slot);
               a.found_value = v;
            end
         end
         CMD_ERASE: begin
            i = find_key(k);
            if (i < 0) a.status = ST_MISS;
            else begin
               a.handle = SLOT_BITS'(i);
               order_unlink(i);
               unpin(i);
            end
         end
         default: begin
            a.handle = s;
            if (slot_refs[s] == 0) a.status = ST_FREEREL;
            else unpin(s);
         end
      endcase
      a.usage = model_usage;
      return a;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0)
            report_mismatch("result word with nothing expected");
         else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, e.status));
            if (rsp_handle !== e.handle)
               report_mismatch($sformatf("handle %0d, expected %0d", rsp_handle, e.handle));
            if (rsp_found_value !== e.found_value)
               report_mismatch($sformatf("value %h, expected %h", rsp_found_value,
                                         e.found_value));
            if (rsp_usage !== e.usage)
               report_mismatch($sformatf("usage %0d, expected %0d", rsp_usage, e.usage));
         end
      end
   end

   // ---------------- drivers ----------------
   task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [KEY_BITS-1:0] k,
                            input logic [VAL_BITS-1:0] v, input logic [CHG_BITS-1:0] c,
                            input logic [SLOT_BITS-1:0] s);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      // always move off the edge where start was last dropped; busy is high there anyway
      repeat (gap + 1) @(posedge clock);
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_key    <= k;
      req_value  <= v;
      req_charge <= c;
      req_slot   <= s;
      // busy read straight after the edge is its pre-edge value
      do @(posedge clock); while (busy);
      start <= 1'b0;
      last_answer = predict_answer(cmd, k, v, c, s);
      pending_answers.push_back(last_answer);
      if ((cmd == CMD_INSERT || cmd == CMD_LOOKUP) && last_answer.status == ST_OK)
         held_handles.push_back(last_answer.handle);
   endtask

   task automatic wait_all_answered();
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [USE_BITS-1:0] cap);
      wait_all_answered();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_capacity = cap;
   endtask

   // releases every reference until all slots are free
   task automatic release_everything();
      for (int s = 0; s < SLOTS; s++)
         while (slot_refs[s] != 0) send_word(CMD_RELEASE, '0, '0, '0, SLOT_BITS'(s));
      held_handles.delete();
   endtask

   // ---------------- tests ----------------
   task automatic test_basic_commands();
      int h;
      // zero capacity: the new entry is its own oldest and is evicted at once
      write_capacity('0);
      send_word(CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 16'd5, '0);
      h = last_answer.handle;
      send_word(CMD_LOOKUP, 32'h0000_0000, '0, '0, '0);
      send_word(CMD_RELEASE, '0, '0, '0, SLOT_BITS'(h));
      send_word(CMD_RELEASE, '0, '0, '0, SLOT_BITS'(h));   // already free
      send_word(CMD_RELEASE, '0, '0, '0, 4'hF);            // never used
      send_word(CMD_ERASE, 32'hFFFF_FFFF, '0, '0, '0);
      write_capacity(USE_MAX);
      send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, '0);
      send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, '0); // same key
      send_word(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(CMD_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h8001, '0);
      send_word(CMD_LOOKUP, 32'hA5A5_5A5A, '0, '0, '0);
      send_word(CMD_ERASE, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(CMD_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0);
      send_word(CMD_ERASE, 32'hA5A5_5A5A, '0, '0, '0);
      release_everything();
   endtask

   task automatic test_refcount_full();
      int h;
      write_capacity(USE_MAX);
      send_word(CMD_INSERT, 32'h0BAD_F00D, 32'hCAFE_0001, 16'd7, '0);
      h = last_answer.handle;
      no_gaps = 1'b1;
      while (slot_refs[h] < REFS_MAX) send_word(CMD_LOOKUP, 32'h0BAD_F00D, '0, '0, '0);
      no_gaps = 1'b0;
      send_word(CMD_LOOKUP, 32'h0BAD_F00D, '0, '0, '0);
      send_word(CMD_ERASE, 32'h0BAD_F00D, '0, '0, '0);
      no_gaps = 1'b1;
      release_everything();
      no_gaps = 1'b0;
   endtask

   task automatic test_no_free_slot();
      write_capacity(USE_MAX);
      for (int n = 0; n <= SLOTS; n++)
         send_word(CMD_INSERT, 32'h1000_0000 + n, $urandom,
                   CHG_BITS'($urandom_range(0, 50)), '0);
      // a same-key insert is refused too while the table is full
      send_word(CMD_INSERT, 32'h1000_0000, $urandom, 16'd1, '0);
      release_everything();
   endtask

   task automatic test_random(input int words);
      logic [KEY_BITS-1:0] key_pool[12];
      logic [USE_BITS-1:0] caps[6];
      int                  pick;
      int                  idx;
      logic [CHG_BITS-1:0] chg;
      logic [SLOT_BITS-1:0] s;
      caps = '{20'd0, USE_MAX, 20'd100, 20'd1000, 20'd40000, 20'd0};
      caps[5] = USE_BITS'($urandom);
      for (int p = 0; p < 6; p++) begin
         write_capacity(caps[p]);
         key_pool[0] = 32'h0000_0000;
         key_pool[1] = 32'hFFFF_FFFF;
         for (int k = 2; k < 12; k++) key_pool[k] = $urandom;
         for (int n = 0; n < words / 6; n++) begin
            if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            chg = ($urandom_range(0, 9) < 7) ? CHG_BITS'($urandom_range(0, 300))
                : ($urandom_range(0, 1) ? CHG_BITS'($urandom)
                                        : {16{$urandom_range(0, 1) == 1}});
            if (pick < 30)
               send_word(CMD_LOOKUP, ($urandom_range(0, 9) == 0) ? $urandom
                         : key_pool[$urandom_range(0, 11)], $urandom,
                         CHG_BITS'($urandom), SLOT_BITS'($urandom));
            else if (pick < 60)
               send_word(CMD_INSERT, key_pool[$urandom_range(0, 11)], $urandom, chg,
                         SLOT_BITS'($urandom));
            else if (pick < 72)
               send_word(CMD_ERASE, key_pool[$urandom_range(0, 11)], $urandom,
                         CHG_BITS'($urandom), SLOT_BITS'($urandom));
            else begin
               if (held_handles.size() != 0 && $urandom_range(0, 9) != 0) begin
                  idx = $urandom_range(0, held_handles.size() - 1);
                  s   = SLOT_BITS'(held_handles[idx]);
                  held_handles.delete(idx);
               end else
                  s = SLOT_BITS'($urandom);
               send_word(CMD_RELEASE, $urandom, $urandom, CHG_BITS'($urandom), s);
            end
         end
         no_gaps = 1'b0;
      end
   endtask

   // ---------------- sequence ----------------
   initial begin
      start       <= 1'b0;
      req_cmd     <= CMD_LOOKUP;
      req_key     <= '0;
      req_value   <= '0;
      req_charge  <= '0;
      req_slot    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      reset       <= 1'b1;
      no_gaps     = 1'b0;
      model_usage = '0;
      model_capacity = '0;
      for (int j = 0; j < SLOTS; j++) begin
         slot_key[j] = '0; slot_value[j] = '0; slot_charge[j] = '0;
         slot_refs[j] = 0; slot_listed[j] = 1'b0; slot_age[j] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_commands();
      test_refcount_full();
      test_no_free_slot();
      test_random(780);

      wait_all_answered();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
